[rtl/dpfd_pkg.sv]
// Package for the filtered-derivative PID block: widths, codes, payload and
// configuration types. Depends on nothing.
package dpfd_pkg;

  localparam int COEF_FRAC_BITS = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 8;
  localparam int ERR_BITS       = SAMPLE_BITS + 1;
  localparam int HIST_BITS      = 32;
  localparam int NUM_CFG        = 8;
  localparam int CFG_IDX_BITS   = $clog2(NUM_CFG);
  localparam int CFG_DATA_BITS  = (COEF_BITS > SAMPLE_BITS) ? COEF_BITS : SAMPLE_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEF_OUT1 = 3'd0,
    CFG_COEF_OUT2 = 3'd1,
    CFG_COEF_ERR0 = 3'd2,
    CFG_COEF_ERR1 = 3'd3,
    CFG_COEF_ERR2 = 3'd4,
    CFG_SETPOINT  = 3'd5,
    CFG_DRIVE_MIN = 3'd6,
    CFG_DRIVE_MAX = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    LIM_NONE = 2'd0,
    LIM_MAX  = 2'd1,
    LIM_MIN  = 2'd2
  } lim_t;

  typedef struct packed {
    req_t                          req_type;
    logic signed [SAMPLE_BITS-1:0] measured;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] drive;
    lim_t                          limit_hit;
  } out_word_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0]   coef_out1;
    logic signed [COEF_BITS-1:0]   coef_out2;
    logic signed [COEF_BITS-1:0]   coef_err0;
    logic signed [COEF_BITS-1:0]   coef_err1;
    logic signed [COEF_BITS-1:0]   coef_err2;
    logic signed [SAMPLE_BITS-1:0] setpoint;
    logic signed [SAMPLE_BITS-1:0] drive_min;
    logic signed [SAMPLE_BITS-1:0] drive_max;
  } cfg_t;

endpackage

[rtl/dpfd_cfg_regs.sv]
// Configuration register file for the PID block.
// Depends on dpfd_pkg.
module dpfd_cfg_regs
  import dpfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_OUT1: cfg_nxt.coef_out1 = cfg_wdata[COEF_BITS-1:0];
        CFG_COEF_OUT2: cfg_nxt.coef_out2 = cfg_wdata[COEF_BITS-1:0];
        CFG_COEF_ERR0: cfg_nxt.coef_err0 = cfg_wdata[COEF_BITS-1:0];
        CFG_COEF_ERR1: cfg_nxt.coef_err1 = cfg_wdata[COEF_BITS-1:0];
        CFG_COEF_ERR2: cfg_nxt.coef_err2 = cfg_wdata[COEF_BITS-1:0];
        CFG_SETPOINT:  cfg_nxt.setpoint  = cfg_wdata[SAMPLE_BITS-1:0];
        CFG_DRIVE_MIN: cfg_nxt.drive_min = cfg_wdata[SAMPLE_BITS-1:0];
        CFG_DRIVE_MAX: cfg_nxt.drive_max = cfg_wdata[SAMPLE_BITS-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_out1 <= '0;
      cfg_r.coef_out2 <= '0;
      cfg_r.coef_err0 <= '0;
      cfg_r.coef_err1 <= '0;
      cfg_r.coef_err2 <= '0;
      cfg_r.setpoint  <= '0;
      cfg_r.drive_min <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      cfg_r.drive_max <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/dpfd_datapath.sv]
// Difference-equation datapath: five products, floor shift, 32-bit saturation,
// clamp, and the error/output history. Depends on dpfd_pkg.
module dpfd_datapath
  import dpfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  in_word_t  req,
  input  cfg_t      cfg,
  output out_word_t result
);

  localparam int PROD_O_BITS = COEF_BITS + HIST_BITS;
  localparam int PROD_E_BITS = COEF_BITS + ERR_BITS;
  localparam int ACC_BITS    = PROD_O_BITS + 3;

  logic signed [ERR_BITS-1:0]  err_last_r;
  logic signed [ERR_BITS-1:0]  err_before_r;
  logic signed [HIST_BITS-1:0] out_last_r;
  logic signed [HIST_BITS-1:0] out_before_r;

  logic signed [ERR_BITS-1:0]    err;
  logic signed [PROD_O_BITS-1:0] p_o1;
  logic signed [PROD_O_BITS-1:0] p_o2;
  logic signed [PROD_E_BITS-1:0] p_e0;
  logic signed [PROD_E_BITS-1:0] p_e1;
  logic signed [PROD_E_BITS-1:0] p_e2;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [ACC_BITS-1:0]    acc_sh;
  logic [ACC_BITS-HIST_BITS:0]   acc_hi;
  logic signed [HIST_BITS-1:0]   u_sat;
  logic signed [HIST_BITS-1:0]   dmin_x;
  logic signed [HIST_BITS-1:0]   dmax_x;
  logic                          is_clear;

  assign is_clear = (req.req_type == REQ_CLEAR);
  assign err = ERR_BITS'(cfg.setpoint) - ERR_BITS'(req.measured);

  assign p_o1 = cfg.coef_out1 * out_last_r;
  assign p_o2 = cfg.coef_out2 * out_before_r;
  assign p_e0 = cfg.coef_err0 * err;
  assign p_e1 = cfg.coef_err1 * err_last_r;
  assign p_e2 = cfg.coef_err2 * err_before_r;

  assign acc = ACC_BITS'(p_e0) + ACC_BITS'(p_e1) + ACC_BITS'(p_e2)
             - ACC_BITS'(p_o1) - ACC_BITS'(p_o2);
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  assign acc_hi = acc_sh[ACC_BITS-1:HIST_BITS-1];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      u_sat = acc_sh[HIST_BITS-1:0];
    end else if (acc_sh[ACC_BITS-1]) begin
      u_sat = {1'b1, {(HIST_BITS-1){1'b0}}};
    end else begin
      u_sat = {1'b0, {(HIST_BITS-1){1'b1}}};
    end
  end

  assign dmin_x = HIST_BITS'(cfg.drive_min);
  assign dmax_x = HIST_BITS'(cfg.drive_max);

  // max test wins when the limits are crossed
  always_comb begin
    if (is_clear) begin
      result.drive     = '0;
      result.limit_hit = LIM_NONE;
    end else if (u_sat > dmax_x) begin
      result.drive     = cfg.drive_max;
      result.limit_hit = LIM_MAX;
    end else if (u_sat < dmin_x) begin
      result.drive     = cfg.drive_min;
      result.limit_hit = LIM_MIN;
    end else begin
      result.drive     = u_sat[SAMPLE_BITS-1:0];
      result.limit_hit = LIM_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_last_r   <= '0;
      err_before_r <= '0;
      out_last_r   <= '0;
      out_before_r <= '0;
    end else if (adv) begin
      if (is_clear) begin
        err_last_r   <= '0;
        err_before_r <= '0;
        out_last_r   <= '0;
        out_before_r <= '0;
      end else begin
        err_last_r   <= err;
        err_before_r <= err_last_r;
        out_last_r   <= u_sat;
        out_before_r <= out_last_r;
      end
    end
  end

endmodule

[rtl/discrete_pid_filtered_derivative.sv]
// Top level of the filtered-derivative PID block: input word register,
// output word register and handshake. Depends on dpfd_pkg, dpfd_cfg_regs, dpfd_datapath.
//
// Usage:
//   in_valid/in_stall/in_data carry request words (sample or clear).
//   out_valid/out_stall/out_data carry one result word per request:
//   clamped drive and a limit flag (none, max, min).
//   cfg_we/cfg_index/cfg_wdata write the coefficients, setpoint and drive
//   limits; write them only while no request is in flight.
//   Path: input register, datapath, output register. Throughput: one word
//   per cycle while out_stall is low; the output-history feedback closes
//   through the five-multiplier datapath back into the history registers, which sets the rate.
//   Reset: history cleared, coefficients and setpoint zero, limits at the
//   full signed range, both word registers empty.
//   Stall: a stalled result holds in the output register; the input
//   register still takes one more word, then in_stall rises until the
//   receiver drains.
module discrete_pid_filtered_derivative
  import dpfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_word_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_word_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t      cfg;
  out_word_t result;
  in_word_t  s1_r;
  logic      s1_vld_r;
  logic      s1_vld_nxt;
  out_word_t out_r;
  logic      out_vld_r;
  logic      out_vld_nxt;
  logic      out_free;
  logic      adv;

  dpfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dpfd_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .req    (s1_r),
    .cfg    (cfg),
    .result (result)
  );

  assign out_free    = !out_vld_r || !out_stall;
  assign adv         = s1_vld_r && out_free;
  assign in_stall    = s1_vld_r && !out_free;
  assign s1_vld_nxt  = (in_valid && !in_stall) || (s1_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
    if (adv) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[rtl/dpfd_checker.sv]
// Port-level checks for the PID block, bound to the top level.
// Depends on dpfd_pkg and discrete_pid_filtered_derivative.
module dpfd_checker
  import dpfd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result word changed");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with output register empty");

  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.limit_hit == LIM_NONE || out_data.limit_hit == LIM_MAX
                   || out_data.limit_hit == LIM_MIN))
    else $error("bad limit flag");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind discrete_pid_filtered_derivative dpfd_checker u_dpfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
